// ===== hw/rtl/md2_pkg.sv =====
package md2_pkg;

  // block and work buffer geometry
  localparam int unsigned BlkBytes  = 16;
  localparam int unsigned WorkBytes = 48;
  localparam int unsigned NumPasses = 18;

  typedef logic [BlkBytes-1:0][7:0] md2_blk_t;

  // top level sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StComp,
    StPad,
    StLoad,
    StDone
  } md2_state_e;

  // where to go once a compression finishes
  typedef enum logic [1:0] {
    NxIdle,
    NxPad,
    NxSum,
    NxOut
  } md2_next_e;

  // control from the sequencer to the cell chain
  typedef struct packed {
    logic       start;
    logic       lane_en;
    logic [3:0] lane_pos;
    logic [7:0] lane_byte;
    logic       sum_load;
    logic       clear;
  } md2_chain_ctrl_t;

  // pi-derived substitution table
  localparam logic [7:0] Sbox [256] = '{
    8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61, 8'd54, 8'd84, 8'd161, 8'd236, 8'd240, 8'd6, 8'd19,
    8'd98, 8'd167, 8'd5, 8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43, 8'd217, 8'd188, 8'd76, 8'd130, 8'd202,
    8'd30, 8'd155, 8'd87, 8'd60, 8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66, 8'd111, 8'd24, 8'd138, 8'd23, 8'd229, 8'd18,
    8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63,
    8'd148, 8'd194, 8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33,
    8'd128, 8'd127, 8'd93, 8'd154, 8'd90, 8'd144, 8'd50, 8'd39,
    8'd53, 8'd62, 8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25, 8'd48, 8'd179, 8'd72, 8'd165, 8'd181, 8'd209,
    8'd215, 8'd94, 8'd146, 8'd42, 8'd172, 8'd86, 8'd170, 8'd198,
    8'd79, 8'd184, 8'd56, 8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241,
    8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91, 8'd207, 8'd101, 8'd230, 8'd45, 8'd168, 8'd2,
    8'd27, 8'd96, 8'd37, 8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28, 8'd70, 8'd97, 8'd105, 8'd52, 8'd64, 8'd126, 8'd15,
    8'd85, 8'd71, 8'd163, 8'd35, 8'd221, 8'd81, 8'd175, 8'd58,
    8'd195, 8'd92, 8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40, 8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65, 8'd129, 8'd77, 8'd82,
    8'd106, 8'd220, 8'd55, 8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57,
    8'd242, 8'd239, 8'd183, 8'd14, 8'd102, 8'd88, 8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75, 8'd10,
    8'd49, 8'd68, 8'd80, 8'd180, 8'd143, 8'd237, 8'd31, 8'd26,
    8'd219, 8'd153, 8'd141, 8'd51, 8'd159, 8'd17, 8'd131, 8'd20
  };

  function automatic logic [7:0] md2_sbox(input logic [7:0] x);
    return Sbox[x];
  endfunction

endpackage

// ===== hw/rtl/md2_cell.sv =====
module md2_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] shift_data_i,
  input  logic       load_i,
  input  logic [7:0] load_data_i,
  input  logic       clear_i,
  output logic [7:0] q_o
);

  logic [7:0] q_q, q_d;

  // clear wins, then a parallel load, then the shift from the neighbor
  always_comb begin
    priority if (clear_i) begin
      q_d = '0;
    end else if (load_i) begin
      q_d = load_data_i;
    end else if (shift_i) begin
      q_d = shift_data_i;
    end else begin
      q_d = q_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== hw/rtl/md2_chain.sv =====
module md2_chain (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  md2_pkg::md2_chain_ctrl_t ctrl_i,
  input  md2_pkg::md2_blk_t        sum_i,
  output md2_pkg::md2_blk_t        hash_o,
  output logic                     done_o
);

  import md2_pkg::*;

  localparam int unsigned KW = $clog2(WorkBytes);
  localparam int unsigned PW = $clog2(NumPasses);

  logic [7:0]    cell_q    [WorkBytes];
  logic [7:0]    shift_in  [WorkBytes];
  logic          cell_load [WorkBytes];
  logic [7:0]    load_data [WorkBytes];
  logic          cell_clr  [WorkBytes];
  logic [7:0]    lane      [BlkBytes];

  logic          busy_q, busy_d;
  logic [KW-1:0] k_q, k_d;
  logic [PW-1:0] pass_q, pass_d;
  logic [7:0]    t_q, t_d;
  logic [7:0]    mix;
  logic          last_step;

  // head of the ring: chain the byte leaving cell 0 through the sbox
  assign mix       = cell_q[0] ^ md2_sbox(t_q);
  assign last_step = (k_q == KW'(WorkBytes - 1)) && (pass_q == PW'(NumPasses - 1));
  assign done_o    = busy_q && last_step;

  // pass and position counters
  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    pass_d = pass_q;
    t_d    = t_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      k_d    = '0;
      pass_d = '0;
      t_d    = '0;
    end else if (busy_q) begin
      if (k_q == KW'(WorkBytes - 1)) begin
        k_d    = '0;
        pass_d = pass_q + 1'b1;
        t_d    = mix + 8'(pass_q);
        if (last_step) begin
          busy_d = 1'b0;
        end
      end else begin
        k_d = k_q + 1'b1;
        t_d = mix;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      pass_q <= '0;
      t_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
      pass_q <= pass_d;
      t_q    <= t_d;
    end
  end

  // per-cell load, clear and shift wiring
  always_comb begin
    for (int i = 0; i < WorkBytes; i++) begin
      cell_load[i] = 1'b0;
      load_data[i] = '0;
      cell_clr[i]  = 1'b0;
      shift_in[i]  = (i == WorkBytes - 1) ? mix : cell_q[(i + 1) % WorkBytes];
    end
    for (int k = 0; k < BlkBytes; k++) begin
      lane[k] = ctrl_i.sum_load ? sum_i[k] : ctrl_i.lane_byte;
      cell_clr[k] = ctrl_i.clear;
      cell_load[BlkBytes + k]     = ctrl_i.sum_load ||
                                    (ctrl_i.lane_en && (ctrl_i.lane_pos == 4'(k)));
      cell_load[2 * BlkBytes + k] = cell_load[BlkBytes + k];
      load_data[BlkBytes + k]     = lane[k];
      load_data[2 * BlkBytes + k] = lane[k] ^ cell_q[k];
    end
  end

  // the ring of work buffer cells
  for (genvar i = 0; i < WorkBytes; i++) begin : g_cell
    md2_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (busy_q),
      .shift_data_i(shift_in[i]),
      .load_i      (cell_load[i]),
      .load_data_i (load_data[i]),
      .clear_i     (cell_clr[i]),
      .q_o         (cell_q[i])
    );
  end

  // cells 0 to 15 hold the hash state between blocks
  always_comb begin
    for (int k = 0; k < BlkBytes; k++) begin
      hash_o[k] = cell_q[k];
    end
  end

endmodule

// ===== hw/rtl/md2_hash.sv =====
// md2 message digest, one message byte per input transaction
//
// input channel (in_valid_i / in_ready_o): data_byte_i, byte_valid_i, last_i.
// a transaction with byte_valid_i low carries no byte; with last_i high it
// ends the message, so a lone empty final transaction hashes the empty message.
// output channel (out_valid_o / out_ready_i): the 16-byte digest as two
// 64-bit halves, one transaction per message.
//
// a byte that does not fill a block, in a transaction without last_i, leaves
// in_ready_o high for the next transaction. a byte that fills a block starts
// a compression (18 passes around a ring of 48 byte cells, one sbox lookup
// per cycle) and the next transaction is taken only once it finishes. the end
// of a message adds 1 to 16 padding bytes, one compression, a load of the
// checksum block, a second compression of the checksum and a move of the
// digest into the output register, with one more compression first when the
// final transaction fills a block.
//
// reset clears hash state, checksum and block position. a digest waiting on
// a stalled receiver holds in the output register; the next message is taken
// meanwhile and only its finish waits for the register to free up.
module md2_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_high_o,
  output logic [63:0] digest_low_o
);

  import md2_pkg::*;

  md2_state_e      state_q, state_d;
  md2_next_e       next_q, next_d;
  logic [4:0]      pad_q, pad_d;
  logic [3:0]      pos_q, pos_d;
  logic [7:0]      carry_q, carry_d;
  md2_blk_t        sum_q, sum_d;
  logic            out_valid_q, out_valid_d;
  logic [63:0]     high_q, high_d, low_q, low_d;

  md2_chain_ctrl_t ctrl;
  md2_blk_t        hash;
  logic            comp_done;
  logic            in_fire;
  logic            absorb;
  logic [7:0]      absorb_byte;
  logic [7:0]      cks;
  logic [3:0]      pos_after;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // checksum byte for the byte being absorbed
  assign absorb_byte = (state_q == StPad) ? {3'b000, pad_q} : data_byte_i;
  assign absorb      = (in_fire && byte_valid_i) || (state_q == StPad);
  assign cks         = md2_sbox(absorb_byte ^ carry_q) ^ sum_q[pos_q];
  assign pos_after   = byte_valid_i ? pos_q + 1'b1 : pos_q;

  // sequencer
  always_comb begin
    state_d         = state_q;
    next_d          = next_q;
    pad_d           = pad_q;
    pos_d           = pos_q;
    carry_d         = carry_q;
    sum_d           = sum_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    high_d          = high_q;
    low_d           = low_q;
    ctrl            = '0;
    ctrl.lane_pos   = pos_q;
    ctrl.lane_byte  = absorb_byte;

    if (absorb) begin
      sum_d[pos_q]  = cks;
      carry_d       = cks;
      pos_d         = pos_q + 1'b1;
      ctrl.lane_en  = 1'b1;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (byte_valid_i && (pos_q == 4'd15)) begin
            ctrl.start = 1'b1;
            next_d     = last_i ? NxPad : NxIdle;
            state_d    = StComp;
          end else if (last_i) begin
            pad_d   = 5'd16 - {1'b0, pos_after};
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (pos_q == 4'd15) begin
          ctrl.start = 1'b1;
          next_d     = NxSum;
          state_d    = StComp;
        end
      end
      StComp: begin
        if (comp_done) begin
          unique case (next_q)
            NxIdle: state_d = StIdle;
            NxPad: begin
              pad_d   = 5'd16;
              state_d = StPad;
            end
            NxSum:  state_d = StLoad;
            NxOut:  state_d = StDone;
            default: state_d = StIdle;
          endcase
        end
      end
      StLoad: begin
        // checksum block into the work buffer, then compress it
        ctrl.sum_load = 1'b1;
        ctrl.start    = 1'b1;
        next_d        = NxOut;
        state_d       = StComp;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          for (int i = 0; i < 8; i++) begin
            high_d[63 - 8 * i -: 8] = hash[i];
            low_d[63 - 8 * i -: 8]  = hash[8 + i];
          end
          out_valid_d = 1'b1;
          ctrl.clear  = 1'b1;
          sum_d       = '0;
          carry_d     = '0;
          pos_d       = '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      next_q      <= NxIdle;
      pad_q       <= '0;
      pos_q       <= '0;
      carry_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      pad_q       <= pad_d;
      pos_q       <= pos_d;
      carry_q     <= carry_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // digest output register
  always_ff @(posedge clk_i) begin
    high_q <= high_d;
    low_q  <= low_d;
  end

  md2_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .sum_i (sum_q),
    .hash_o(hash),
    .done_o(comp_done)
  );

  assign out_valid_o   = out_valid_q;
  assign digest_high_o = high_q;
  assign digest_low_o  = low_q;

endmodule

// ===== tb/md2_hash_test.sv =====
`timescale 1ns / 1ps

package md2_digest_check_pkg;

  typedef logic [15:0][7:0] blk16_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } digest_t;

  // byte substitution table derived from the digits of pi
  localparam logic [7:0] SBOX_VALUES [256] = '{
    8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61, 8'd54, 8'd84, 8'd161, 8'd236, 8'd240, 8'd6, 8'd19,
    8'd98, 8'd167, 8'd5, 8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43, 8'd217, 8'd188, 8'd76, 8'd130, 8'd202,
    8'd30, 8'd155, 8'd87, 8'd60, 8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66, 8'd111, 8'd24, 8'd138, 8'd23, 8'd229, 8'd18,
    8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63,
    8'd148, 8'd194, 8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33,
    8'd128, 8'd127, 8'd93, 8'd154, 8'd90, 8'd144, 8'd50, 8'd39,
    8'd53, 8'd62, 8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25, 8'd48, 8'd179, 8'd72, 8'd165, 8'd181, 8'd209,
    8'd215, 8'd94, 8'd146, 8'd42, 8'd172, 8'd86, 8'd170, 8'd198,
    8'd79, 8'd184, 8'd56, 8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241,
    8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91, 8'd207, 8'd101, 8'd230, 8'd45, 8'd168, 8'd2,
    8'd27, 8'd96, 8'd37, 8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28, 8'd70, 8'd97, 8'd105, 8'd52, 8'd64, 8'd126, 8'd15,
    8'd85, 8'd71, 8'd163, 8'd35, 8'd221, 8'd81, 8'd175, 8'd58,
    8'd195, 8'd92, 8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40, 8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65, 8'd129, 8'd77, 8'd82,
    8'd106, 8'd220, 8'd55, 8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57,
    8'd242, 8'd239, 8'd183, 8'd14, 8'd102, 8'd88, 8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75, 8'd10,
    8'd49, 8'd68, 8'd80, 8'd180, 8'd143, 8'd237, 8'd31, 8'd26,
    8'd219, 8'd153, 8'd141, 8'd51, 8'd159, 8'd17, 8'd131, 8'd20
  };

  // running md2 digest of the byte stream, plus the digests still owed
  class digest_board;
    blk16_t      hash_st;
    blk16_t      blk_bytes;
    blk16_t      sum_bytes;
    logic [7:0]  sum_link;
    int unsigned fill;
    digest_t     awaited_digests [$];
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      hash_st   = '0;
      blk_bytes = '0;
      sum_bytes = '0;
      sum_link  = 8'd0;
      fill      = 0;
    endfunction

    // 18 passes of sbox chaining over state, block and their xor
    function void mix_block(input blk16_t src);
      logic [7:0] work [48];
      logic [7:0] t;
      t = 8'd0;
      for (int k = 0; k < 16; k++) begin
        work[k]      = hash_st[k];
        work[16 + k] = src[k];
        work[32 + k] = src[k] ^ hash_st[k];
      end
      for (int p = 0; p < 18; p++) begin
        for (int k = 0; k < 48; k++) begin
          t       = work[k] ^ SBOX_VALUES[t];
          work[k] = t;
        end
        t = t + 8'(p);
      end
      for (int k = 0; k < 16; k++) hash_st[k] = work[k];
    endfunction

    // checksum update and block fill for one byte
    function void take_byte(input logic [7:0] b);
      logic [7:0] c;
      c = SBOX_VALUES[b ^ sum_link] ^ sum_bytes[fill];
      sum_bytes[fill] = c;
      sum_link        = c;
      blk_bytes[fill] = b;
      if (fill == 15) begin
        mix_block(blk_bytes);
        fill = 0;
      end else begin
        fill++;
      end
    endfunction

    // accepted input transaction
    function void note_transaction(input logic [7:0] d, input logic bv, input logic lst);
      int unsigned pad;
      digest_t     dg;
      if (bv) take_byte(d);
      if (lst) begin
        pad = 16 - fill;
        repeat (pad) take_byte(8'(pad));
        mix_block(sum_bytes);
        for (int i = 0; i < 8; i++) begin
          dg.hi[63 - 8 * i -: 8] = hash_st[i];
          dg.lo[63 - 8 * i -: 8] = hash_st[8 + i];
        end
        awaited_digests.push_back(dg);
        clear_state();
      end
    endfunction

    // accepted output transaction against the oldest owed digest
    function void check_digest(input logic [63:0] hi, input logic [63:0] lo);
      digest_t want;
      if (awaited_digests.size() == 0) begin
        $error("unexpected digest: digest_high %h digest_low %h", hi, lo);
        errors++;
        return;
      end
      want = awaited_digests.pop_front();
      if (hi !== want.hi) begin
        $error("digest_high: expected %h, got %h", want.hi, hi);
        errors++;
      end
      if (lo !== want.lo) begin
        $error("digest_low: expected %h, got %h", want.lo, lo);
        errors++;
      end
    endfunction
  endclass

endpackage

module md2_hash_test;
  import md2_digest_check_pkg::*;

  typedef enum int unsigned {
    FillZero,
    FillOnes,
    FillRandom
  } fill_e;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        byte_valid_i = 1'b0;
  logic        last_i       = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [63:0] digest_high_o;
  logic [63:0] digest_low_o;

  digest_board board = new();
  bit          calm = 1'b0;
  int unsigned counted = 0;

  md2_hash DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_high_o(digest_high_o),
    .digest_low_o (digest_low_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin : run_limit
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // one input transaction, then maybe a burst of idle cycles
  task automatic send_item(input logic [7:0] d, input logic bv, input logic lst);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    byte_valid_i <= bv;
    last_i       <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_transaction(d, bv, lst);
    if (bv || lst) counted++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // whole message, with stray idle transactions between bytes
  task automatic send_message(input int unsigned len, input bit sep_final, input fill_e mode);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if (mode == FillZero) b = 8'h00;
      else if (mode == FillOnes) b = 8'hFF;
      else b = 8'($urandom);
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(b, 1'b1, !sep_final && (i == len - 1));
    end
    if (sep_final) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // digest receiver with random stall bursts
  initial begin : digest_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        board.check_digest(digest_high_o, digest_low_o);
      if (hold == 0 && !calm && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 12);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned r;
    int unsigned len;
    int unsigned pick;
    fill_e       mode;
    bit          sep;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, then one-byte messages at both extremes
    send_item(8'($urandom), 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    // "abc" with an idle transaction inside and an empty final transaction
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // exactly one block, so padding is a full block
    for (int i = 0; i < 16; i++) send_item(8'(i * 17), 1'b1, i == 15);

    // random messages, mostly short, some crossing several blocks
    while (counted < 1800) begin
      r = $urandom_range(0, 19);
      if (r < 8) len = $urandom_range(0, 17);
      else if (r < 16) len = $urandom_range(14, 40);
      else if (r < 19) len = $urandom_range(41, 80);
      else len = $urandom_range(81, 160);
      pick = $urandom_range(0, 7);
      if (pick == 0) mode = FillZero;
      else if (pick == 1) mode = FillOnes;
      else mode = FillRandom;
      sep = (len == 0) || ($urandom_range(0, 1) == 1);
      if (counted > 1650) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_message(len, sep, mode);
    end
    in_valid_i <= 1'b0;

    // drain, then watch for stray digests
    while (board.awaited_digests.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
